/* rtl/core/tgp_pkg.sv */
// Shared types and constants for the turtle grid plotter.
`default_nettype none

package tgp_pkg;

  // Command codes; 6 and 7 are unused and act as no-ops
  typedef enum logic [2:0] {
    OP_PEN_UP   = 3'd0,
    OP_PEN_DOWN = 3'd1,
    OP_TURN_R   = 3'd2,
    OP_TURN_L   = 3'd3,
    OP_MOVE     = 3'd4,
    OP_DUMP     = 3'd5
  } opcode_t;

  // Heading codes
  localparam logic [1:0] HEAD_UP    = 2'd0;
  localparam logic [1:0] HEAD_RIGHT = 2'd1;
  localparam logic [1:0] HEAD_DOWN  = 2'd2;
  localparam logic [1:0] HEAD_LEFT  = 2'd3;

  // Result field widths and the dump row limit
  localparam int ROW_BITS_W = 32;
  localparam int IDX_W      = 5;
  localparam int MAX_DUMP   = 32;

  // Controller to datapath
  typedef struct packed {
    logic    exec;         // apply the accepted command to the turtle state
    opcode_t op;
    logic    rd_cur;       // read canvas row at the cursor
    logic    rd_next;      // advance the cursor and read that row
    logic    wr;           // write back the row at the cursor, merged with the mask
    logic    emit_status;  // load a status result
    logic    emit_row;     // load a dump row result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;   // output register empty or draining this cycle
    logic cur_at_end;  // cursor sits on the final row of the sweep
    logic pen;         // pen is down
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/tgp_ctrl.sv */
// Command sequencer for the turtle grid plotter.
`default_nettype none

module tgp_ctrl
  import tgp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [2:0] in_opcode,
  output logic            in_ready,
  output dp_cmd_t         cmd,
  input  dp_sts_t         sts
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EMIT   = 6'b000010,
    S_MV_RD  = 6'b000100,
    S_MV_WR  = 6'b001000,
    S_DP_RD  = 6'b010000,
    S_DP_OUT = 6'b100000
  } state_t;

  state_t  state_r, state_nxt;
  opcode_t op;

  assign op       = opcode_t'(in_opcode);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.op          = op;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.exec = 1'b1;
          case (op)
            OP_MOVE: state_nxt = sts.pen ? S_MV_RD : S_EMIT;
            OP_DUMP: state_nxt = S_DP_RD;
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_MV_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_MV_WR;
      end
      S_MV_WR: begin
        cmd.wr = 1'b1;
        if (sts.cur_at_end) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_DP_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_DP_OUT;
      end
      S_DP_OUT: begin
        if (sts.slot_free) begin
          cmd.emit_row = 1'b1;
          if (sts.cur_at_end) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tgp_dp.sv */
// Turtle state, canvas memory, row cursor and result register.
`default_nettype none

module tgp_dp
  import tgp_pkg::*;
#(
  parameter int GRID_SIZE = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IDX_W-1:0]      in_distance,
  input  dp_cmd_t                    cmd,
  output dp_sts_t                    sts,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [ROW_BITS_W-1:0]      out_row_bits,
  output logic [IDX_W-1:0]           out_row_number,
  output logic [IDX_W-1:0]           out_turtle_row,
  output logic [IDX_W-1:0]           out_turtle_col,
  output logic [1:0]                 out_heading,
  output logic                       out_pen_down,
  output logic                       out_last
);

  localparam int PW     = $clog2(GRID_SIZE);
  localparam int SW     = ((PW > IDX_W) ? PW : IDX_W) + 1;
  localparam int PWW    = (PW > IDX_W) ? PW : IDX_W;
  localparam int RWW    = (GRID_SIZE > ROW_BITS_W) ? GRID_SIZE : ROW_BITS_W;
  localparam int DUMP_N = (GRID_SIZE < MAX_DUMP) ? GRID_SIZE : MAX_DUMP;
  localparam logic [PW-1:0] DUMP_LAST = PW'(DUMP_N - 1);
  localparam logic [SW-1:0] LIM       = SW'(GRID_SIZE - 1);

  // Turtle state
  logic [PW-1:0] pos_row_r, pos_row_nxt;
  logic [PW-1:0] pos_col_r, pos_col_nxt;
  logic [1:0]    head_r, head_nxt;
  logic          pen_r, pen_nxt;

  // Row sweep
  logic [PW-1:0]        cur_r, cur_nxt;
  logic [PW-1:0]        end_r, end_nxt;
  logic [GRID_SIZE-1:0] mask_r, mask_nxt;

  // Canvas
  logic [GRID_SIZE-1:0] canvas [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_vld_r;
  logic [GRID_SIZE-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic [PW-1:0]        rd_addr;
  logic                 rd_en;
  logic [GRID_SIZE-1:0] rd_row;
  logic [GRID_SIZE-1:0] wr_data;

  // Move arithmetic
  logic [SW-1:0] d_ext, row_ext, col_ext;
  logic [SW-1:0] row_up, row_dn, col_up, col_dn, row_sum, col_sum;
  logic [SW-1:0] clo, chi;

  // Result register
  logic                  out_valid_r;
  logic [ROW_BITS_W-1:0] out_row_bits_r;
  logic [IDX_W-1:0]      out_row_number_r;
  logic [IDX_W-1:0]      out_turtle_row_r;
  logic [IDX_W-1:0]      out_turtle_col_r;
  logic [1:0]            out_heading_r;
  logic                  out_pen_down_r;
  logic                  out_last_r;
  logic [RWW-1:0]        row_wide;
  logic [PWW-1:0]        cur_wide, prow_wide, pcol_wide;

  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.cur_at_end = (cur_r == end_r);
  assign sts.pen        = pen_r;

  assign d_ext   = SW'(in_distance);
  assign row_ext = SW'(pos_row_r);
  assign col_ext = SW'(pos_col_r);
  assign row_sum = row_ext + d_ext;
  assign col_sum = col_ext + d_ext;
  assign row_up  = (row_ext >= d_ext) ? row_ext - d_ext : '0;
  assign col_up  = (col_ext >= d_ext) ? col_ext - d_ext : '0;
  assign row_dn  = (row_sum > LIM) ? LIM : row_sum;
  assign col_dn  = (col_sum > LIM) ? LIM : col_sum;

  always_comb begin
    pos_row_nxt = pos_row_r;
    pos_col_nxt = pos_col_r;
    head_nxt    = head_r;
    pen_nxt     = pen_r;
    cur_nxt     = cur_r;
    end_nxt     = end_r;
    mask_nxt    = mask_r;
    clo         = col_ext;
    chi         = col_ext;
    if (cmd.exec) begin
      case (cmd.op)
        OP_PEN_UP:   pen_nxt  = 1'b0;
        OP_PEN_DOWN: pen_nxt  = 1'b1;
        OP_TURN_R:   head_nxt = head_r + 2'd1;
        OP_TURN_L:   head_nxt = head_r + 2'd3;
        OP_MOVE: begin
          // Vertical moves sweep rows on one column; horizontal ones touch one row
          cur_nxt = pos_row_r;
          end_nxt = pos_row_r;
          case (head_r)
            HEAD_UP: begin
              pos_row_nxt = PW'(row_up);
              cur_nxt     = PW'(row_up);
            end
            HEAD_DOWN: begin
              pos_row_nxt = PW'(row_dn);
              end_nxt     = PW'(row_dn);
            end
            HEAD_RIGHT: begin
              pos_col_nxt = PW'(col_dn);
              chi         = col_dn;
            end
            default: begin
              pos_col_nxt = PW'(col_up);
              clo         = col_up;
            end
          endcase
          for (int c = 0; c < GRID_SIZE; c++) begin
            mask_nxt[c] = (SW'(c) >= clo) && (SW'(c) <= chi);
          end
        end
        OP_DUMP: begin
          cur_nxt = '0;
          end_nxt = DUMP_LAST;
        end
        default: ;
      endcase
    end else if (cmd.rd_next) begin
      cur_nxt = cur_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_row_r <= '0;
      pos_col_r <= '0;
      head_r    <= HEAD_RIGHT;
      pen_r     <= 1'b0;
    end else begin
      pos_row_r <= pos_row_nxt;
      pos_col_r <= pos_col_nxt;
      head_r    <= head_nxt;
      pen_r     <= pen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    end_r  <= end_nxt;
    mask_r <= mask_nxt;
  end

  // Canvas port: write at the cursor, read at the cursor or the row after it
  assign rd_en   = cmd.rd_cur || cmd.rd_next;
  assign rd_addr = cmd.rd_next ? cur_r + PW'(1) : cur_r;
  assign rd_row  = rd_vld_r ? rd_data_r : '0;
  assign wr_data = rd_row | mask_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      canvas[cur_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= canvas[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.wr) begin
      row_vld_r[cur_r] <= 1'b1;
    end
  end

  // Result register
  assign row_wide  = RWW'(rd_row);
  assign cur_wide  = PWW'(cur_r);
  assign prow_wide = PWW'(pos_row_r);
  assign pcol_wide = PWW'(pos_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_status || cmd.emit_row) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status || cmd.emit_row) begin
      out_row_bits_r   <= cmd.emit_row ? row_wide[ROW_BITS_W-1:0] : '0;
      out_row_number_r <= cmd.emit_row ? cur_wide[IDX_W-1:0] : '0;
      out_last_r       <= cmd.emit_status || (cur_r == end_r);
      out_turtle_row_r <= prow_wide[IDX_W-1:0];
      out_turtle_col_r <= pcol_wide[IDX_W-1:0];
      out_heading_r    <= head_r;
      out_pen_down_r   <= pen_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_bits   = out_row_bits_r;
  assign out_row_number = out_row_number_r;
  assign out_turtle_row = out_turtle_row_r;
  assign out_turtle_col = out_turtle_col_r;
  assign out_heading    = out_heading_r;
  assign out_pen_down   = out_pen_down_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

/* rtl/core/turtle_grid_plotter_core.sv */
// Top level of the turtle grid plotter: sequencer plus datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   in_      | in_valid / in_ready  | in_opcode[2:0], in_distance[4:0]
//   out_     | out_valid/out_ready  | out_row_bits[31:0], out_row_number[4:0],
//            |                      | out_turtle_row/col[4:0], out_heading[1:0],
//            |                      | out_pen_down, out_last
//
// Pen, turn, unused codes and pen-up moves touch no canvas rows. A pen-down move
// touches 1 row when horizontal, up to min(GRID_SIZE, 32) when vertical. A dump reads
// min(GRID_SIZE, 32) rows, one row per cycle while the output is not stalled.
// Reset clears the canvas at once through per-row valid bits; no sweep follows.
// A stalled output holds the result register and the sequencer waits on it;
// a new command is taken whenever the sequencer is idle, even with a result pending.
`default_nettype none

module turtle_grid_plotter_core
  import tgp_pkg::*;
#(
  parameter int GRID_SIZE = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            in_opcode,
  input  wire logic [IDX_W-1:0]      in_distance,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ROW_BITS_W-1:0]      out_row_bits,
  output logic [IDX_W-1:0]           out_row_number,
  output logic [IDX_W-1:0]           out_turtle_row,
  output logic [IDX_W-1:0]           out_turtle_col,
  output logic [1:0]                 out_heading,
  output logic                       out_pen_down,
  output logic                       out_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: decode the transaction and step through row sweeps
  tgp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: turtle state, canvas rows and the result register
  tgp_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_distance    (in_distance),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_row_bits   (out_row_bits),
    .out_row_number (out_row_number),
    .out_turtle_row (out_turtle_row),
    .out_turtle_col (out_turtle_col),
    .out_heading    (out_heading),
    .out_pen_down   (out_pen_down),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

/* rtl/core/tgp_checker.sv */
// Port-level checks for the turtle grid plotter, bound to the top level.
`default_nettype none

module tgp_checker #(
  parameter int GRID_SIZE = 32
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_row_bits,
  input wire logic [4:0]  out_row_number,
  input wire logic [4:0]  out_turtle_row,
  input wire logic [4:0]  out_turtle_col,
  input wire logic        out_last
);

  localparam int DUMP_N = (GRID_SIZE < 32) ? GRID_SIZE : 32;
  localparam logic [4:0] LAST_ROW = 5'(DUMP_N - 1);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_bits) && $stable(out_last))
    else $error("result changed while stalled");

  // Only the final dump row may carry the last row number
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_row_number < LAST_ROW)
    else $error("non-final dump row out of range");

  // Dump rows stream back to back with rising row numbers and a fixed turtle
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid
      && out_row_number == $past(out_row_number) + 5'd1
      && out_turtle_row == $past(out_turtle_row)
      && out_turtle_col == $past(out_turtle_col))
    else $error("dump row sequence broken");

  // No command is taken in the middle of a dump
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input accepted during dump");

endmodule

bind turtle_grid_plotter_core tgp_checker #(
  .GRID_SIZE (GRID_SIZE)
) u_tgp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_row_bits   (out_row_bits),
  .out_row_number (out_row_number),
  .out_turtle_row (out_turtle_row),
  .out_turtle_col (out_turtle_col),
  .out_last       (out_last)
);

`default_nettype wire
